@@ rtl/core/npa_pkg.sv @@
// Shared widths, constants and the power-of-ten table for the NowCast average block.
package npa_pkg;

    localparam int PM_W  = 10;
    localparam int AQI_W = 11;
    localparam int POW_W = 37;
    localparam int NUM_W = 51;
    localparam int DEN_W = 41;
    localparam int WGT_W = 4;
    localparam int RN_W  = 14;
    localparam int Q_W   = 10;

    localparam logic [PM_W-1:0]  PM_MAX     = 10'd1023;
    localparam logic [WGT_W-1:0] WGT_FLOOR  = 4'd5;
    localparam logic [WGT_W-1:0] WGT_TOP    = 4'd10;

    function automatic logic [POW_W-1:0] pow10(input logic [3:0] m);
        logic [POW_W-1:0] p;
        case (m)
            4'd0:    p = 37'd1;
            4'd1:    p = 37'd10;
            4'd2:    p = 37'd100;
            4'd3:    p = 37'd1000;
            4'd4:    p = 37'd10000;
            4'd5:    p = 37'd100000;
            4'd6:    p = 37'd1000000;
            4'd7:    p = 37'd10000000;
            4'd8:    p = 37'd100000000;
            4'd9:    p = 37'd1000000000;
            4'd10:   p = 37'd10000000000;
            4'd11:   p = 37'd100000000000;
            default: p = 37'd0;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/core/npa_cell.sv @@
// One window cell: holds a reading and passes it to the next cell when the chain shifts.
module npa_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  logic [npa_pkg::PM_W-1:0] d,
    output logic [npa_pkg::PM_W-1:0] q
);
    import npa_pkg::*;

    logic [PM_W-1:0] val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (shift)
        begin
            val_reg <= d;
        end
    end

    assign q = val_reg;

endmodule

@@ rtl/core/npa_aqi.sv @@
// Piecewise-linear air quality index from the averaged reading.
module npa_aqi (
    input  logic [npa_pkg::PM_W-1:0]  avg,
    output logic [npa_pkg::AQI_W-1:0] index
);
    import npa_pkg::*;

    logic [5:0]  x12;
    logic [11:0] n23;
    logic [23:0] p23;
    logic [7:0]  q23;
    logic [11:0] r23;
    logic [9:0]  n12;
    logic [23:0] p12;
    logic [7:0]  q12;
    logic [9:0]  r12;
    logic [9:0]  d35;
    logic [11:0] t35;
    logic [9:0]  d55;

    always_comb
    begin
        // Divisions by 23 and 12 use a reciprocal multiply with one correction step.
        x12 = 6'(avg - 10'd12);
        n23 = 12'(x12) * 12'd50;
        p23 = 24'(n23) * 24'd2849;
        q23 = p23[23:16];
        r23 = n23 - 12'(q23) * 12'd23;
        if (r23 >= 12'd23)
        begin
            q23 = q23 + 8'd1;
        end
        n12 = 10'(avg[3:0]) * 10'd50;
        p12 = 24'(n12) * 24'd5461;
        q12 = p12[23:16];
        r12 = n12 - 10'(q12) * 10'd12;
        if (r12 >= 10'd12)
        begin
            q12 = q12 + 8'd1;
        end
        d35 = avg - 10'd35;
        t35 = 12'(d35) * 12'd5;
        d55 = avg - 10'd55;

        if (avg > 10'd150)
        begin
            index = AQI_W'(avg) + 11'd50;
        end
        else if (avg > 10'd55)
        begin
            index = 11'd150 + AQI_W'(d55[9:1]);
        end
        else if (avg > 10'd35)
        begin
            index = 11'd100 + AQI_W'(t35[11:1]);
        end
        else if (avg > 10'd12)
        begin
            index = 11'd50 + AQI_W'(q23);
        end
        else
        begin
            index = AQI_W'(q12);
        end
    end

endmodule

@@ rtl/core/nowcast_pm_average_aqi.sv @@
// Top level: NowCast weighted PM2.5 average over a chain of window cells, plus the index.
//
// Input channel s_axis carries one reading per item in tdata[9:0]; zero means no
// reading. Output channel m_axis carries one result item per input item: the
// weighted average in tdata[9:0] and the air quality index in tdata[20:10].
// The readings sit in a chain of WINDOW_LEN cells. After an item is taken the
// chain rotates once to find the highest and lowest entry, a 4-step divider
// forms the rate, the chain rotates again for a Horner pass that builds the
// weighted sums, and a 10-step divider forms the average. An all-zero window
// skips to the result after the first rotation. The block takes one item at a
// time; s_axis_tready is high only while idle, so the next item is taken only
// after the current result is loaded into the output register. The result waits
// in that register, so the next item may be accepted while it is not yet taken;
// a new result is held back until the receiver takes the old one. Reset clears
// the window to all zero and empties the output register.
module nowcast_pm_average_aqi #(
    parameter int WINDOW_LEN = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pm_reading[9:0], zero fill above
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // average_pm[9:0], air_index[20:10], zero fill above
);
    import npa_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_RATE,
        ST_HORNER,
        ST_DSETUP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PM_W-1:0]     max_reg;
    logic [PM_W-1:0]     min_reg;
    logic [RN_W-1:0]     rn_reg;
    logic [1:0]          rbit_reg;
    logic [WGT_W-1:0]    rq_reg;
    logic [WGT_W-1:0]    w_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0]    term_reg;
    logic [POW_W-1:0]    pw_reg;
    logic                nz_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [Q_W-1:0]      quot_reg;
    logic [3:0]          dbit_reg;
    logic                out_valid_reg;
    logic [23:0]         out_data_reg;

    logic [PM_W-1:0]     win_q [WINDOW_LEN];
    logic [PM_W-1:0]     tail;
    logic [PM_W-1:0]     head_in;
    logic                accept;
    logic                shift;
    logic [POW_W-1:0]    pow_cur;
    logic [PM_W+POW_W-1:0] prod;
    logic [RN_W-1:0]     rtrial;
    logic                rtake;
    logic [WGT_W-1:0]    rq_final;
    logic [NUM_W-1:0]    dtrial;
    logic                dtake;
    logic [AQI_W-1:0]    aqi;
    logic                out_load;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign tail    = win_q[WINDOW_LEN-1];
    assign head_in = accept ? s_axis_tdata[PM_W-1:0] : tail;
    assign shift   = accept || (state_reg == ST_SCAN) ||
                     ((state_reg == ST_HORNER) && (cnt_reg < CNT_W'(WINDOW_LEN)));

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_LEN; gi++)
        begin : g_cell
            npa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     ((gi == 0) ? head_in : win_q[(gi == 0) ? 0 : gi-1]),
                .q     (win_q[gi])
            );
        end
    endgenerate

    npa_aqi u_aqi (
        .avg   (quot_reg),
        .index (aqi)
    );

    assign pow_cur  = pow10(4'(cnt_reg));
    assign prod     = (PM_W+POW_W)'(tail) * (PM_W+POW_W)'(pow_cur);
    assign rtrial   = RN_W'(max_reg) << rbit_reg;
    assign rtake    = rn_reg >= rtrial;
    assign rq_final = rtake ? (rq_reg | (WGT_W'(1) << rbit_reg)) : rq_reg;
    assign dtrial   = NUM_W'(den_reg) << dbit_reg;
    assign dtake    = rem_reg >= dtrial;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg   <= '0;
                        max_reg   <= '0;
                        min_reg   <= PM_MAX;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (tail > max_reg)
                    begin
                        max_reg <= tail;
                    end
                    if (tail < min_reg)
                    begin
                        min_reg <= tail;
                    end
                    if (cnt_reg == CNT_W'(WINDOW_LEN - 1))
                    begin
                        state_reg <= ST_PREP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_PREP:
                begin
                    // An all-empty window reports zero for both results.
                    if (max_reg == '0)
                    begin
                        quot_reg  <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        rn_reg    <= RN_W'(max_reg - min_reg) * RN_W'(10);
                        rbit_reg  <= 2'd3;
                        rq_reg    <= '0;
                        state_reg <= ST_RATE;
                    end
                end
                ST_RATE:
                begin
                    if (rtake)
                    begin
                        rn_reg <= rn_reg - rtrial;
                    end
                    rq_reg <= rq_final;
                    if (rbit_reg == 2'd0)
                    begin
                        w_reg     <= (rq_final >= WGT_FLOOR) ? WGT_FLOOR : (WGT_TOP - rq_final);
                        cnt_reg   <= '0;
                        num_reg   <= '0;
                        den_reg   <= '0;
                        state_reg <= ST_HORNER;
                    end
                    else
                    begin
                        rbit_reg <= rbit_reg - 1'b1;
                    end
                end
                ST_HORNER:
                begin
                    // Oldest entry first; each step scales the sums by the weight.
                    if (cnt_reg < CNT_W'(WINDOW_LEN))
                    begin
                        term_reg <= NUM_W'(prod);
                        pw_reg   <= pow_cur;
                        nz_reg   <= (tail != '0);
                    end
                    if (cnt_reg != '0)
                    begin
                        num_reg <= NUM_W'(num_reg * NUM_W'(w_reg)) + term_reg;
                        den_reg <= DEN_W'(den_reg * DEN_W'(w_reg)) +
                                   (nz_reg ? DEN_W'(pw_reg) : DEN_W'(0));
                    end
                    if (cnt_reg == CNT_W'(WINDOW_LEN))
                    begin
                        state_reg <= ST_DSETUP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DSETUP:
                begin
                    rem_reg   <= num_reg;
                    quot_reg  <= '0;
                    dbit_reg  <= 4'(Q_W - 1);
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (dtake)
                    begin
                        rem_reg            <= rem_reg - dtrial;
                        quot_reg[dbit_reg] <= 1'b1;
                    end
                    if (dbit_reg == 4'd0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        dbit_reg <= dbit_reg - 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        out_data_reg  <= {3'b000, aqi, quot_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted item did not start the window scan");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("finished result not presented");

    a_horner_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HORNER) |-> (cnt_reg <= CNT_W'(WINDOW_LEN)))
        else $error("Horner counter overran the window");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (den_reg != '0))
        else $error("division started with an empty weight sum");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HORNER) |-> ((w_reg >= WGT_FLOOR) && (w_reg <= WGT_TOP)))
        else $error("weight outside its range");

endmodule
